[src/voice_command_frame_matcher_top_defines.svh]
// Assertion macros shared by the RTL.
`ifndef VOICE_COMMAND_FRAME_MATCHER_TOP_DEFINES_SVH
`define VOICE_COMMAND_FRAME_MATCHER_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define VCFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcfm assertion failed");

// Check cons in the cycle after ante.
`define VCFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcfm assertion failed");

`endif

[src/vcfm_pkg.sv]
`default_nettype none

package vcfm_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;

  localparam logic [7:0]  HEADER_BYTE     = 8'hFA;
  localparam logic [7:0]  CHECK_SUM       = 8'hFF;
  localparam logic [7:0]  WAKE_COMMAND    = 8'h00;
  localparam logic [7:0]  WAKE_SOUND      = 8'd6;
  localparam logic [7:0]  SLEEP_SOUND     = 8'd30;
  localparam logic [15:0] WAKE_TIMEOUT_RST = 16'd1000;

  typedef enum logic [2:0] {
    OP_BYTE  = 3'd0,
    OP_ADD   = 3'd1,
    OP_CLEAR = 3'd2,
    OP_POLL  = 3'd3,
    OP_TICK  = 3'd4
  } op_t;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] sound;
    logic       has_action;
  } entry_t;

  typedef struct packed {
    logic       action_valid;
    logic [3:0] action_index;
    logic       sound_valid;
    logic [7:0] sound_id;
    logic [1:0] sound_repeat;
  } res_t;

  typedef struct packed {
    logic take;
    logic exec;
    logic step;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic exec_done;
    logic step_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[src/vcfm_ctrl.sv]
`default_nettype none

module vcfm_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  vcfm_pkg::dp_sts_t   sts,
  output vcfm_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.exec_done ? S_OUT : S_SEARCH;
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.step_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[src/vcfm_datapath.sv]
`default_nettype none

module vcfm_datapath #(
  parameter int unsigned TABLE_DEPTH = vcfm_pkg::TABLE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [2:0]          opcode,
  input  wire  [7:0]          data_byte,
  input  wire  [7:0]          entry_sound,
  input  wire                 entry_has_action,
  input  vcfm_pkg::ctl_cmd_t  cmd,
  output vcfm_pkg::dp_sts_t   sts,
  input  wire                 cfg_we,
  input  wire  [15:0]         cfg_wdata,
  output logic [15:0]         wake_timeout,
  input  wire                 out_tready,
  output logic                out_tvalid,
  output vcfm_pkg::res_t      out_res
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] CNT_MAX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);

  localparam logic [1:0] PH_HEAD  = 2'd0;
  localparam logic [1:0] PH_CMD   = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  localparam vcfm_pkg::res_t WAKE_RES = '{
    action_valid: 1'b0, action_index: 4'd0, sound_valid: 1'b1,
    sound_id: vcfm_pkg::WAKE_SOUND, sound_repeat: 2'd1};
  localparam vcfm_pkg::res_t SLEEP_RES = '{
    action_valid: 1'b0, action_index: 4'd0, sound_valid: 1'b1,
    sound_id: vcfm_pkg::SLEEP_SOUND, sound_repeat: 2'd2};

  vcfm_pkg::entry_t mem [TABLE_DEPTH];
  vcfm_pkg::entry_t rd_q;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic [2:0]       op_r;
  logic [7:0]       data_r;
  logic [7:0]       esnd_r;
  logic             eact_r;

  logic [1:0]       phase_r, phase_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic             awake_r, awake_nxt;
  logic [15:0]      tmo_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  vcfm_pkg::res_t   res_r, res_nxt;
  vcfm_pkg::res_t   out_r;
  logic             out_valid_r, out_valid_nxt;

  logic             asleep;
  logic             slp_awake;
  vcfm_pkg::res_t   slp_res;
  logic             hit;
  logic             last;

  assign asleep = idle_r >= tmo_r;
  assign hit    = rd_q.command == cmd_r;
  assign last   = idx_r == count_r;

  always_comb begin
    slp_awake = awake_r;
    slp_res   = '0;
    if (asleep) begin
      if (awake_r) begin
        slp_awake = 1'b0;
        slp_res   = SLEEP_RES;
      end
    end else begin
      slp_awake = 1'b1;
    end
  end

  assign sts.exec_done = !((op_r == vcfm_pkg::OP_POLL) && pend_r
                           && (cmd_r != vcfm_pkg::WAKE_COMMAND) && (count_r != '0));
  assign sts.step_done = hit || last;
  assign sts.out_free  = !out_valid_r || out_tready;

  assign rd_addr = cmd.exec ? IDX_FIRST : idx_r + IDX_FIRST;
  assign mem_we  = cmd.exec && (op_r == vcfm_pkg::OP_ADD) && (count_r < CNT_MAX);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    pend_nxt  = pend_r;
    count_nxt = count_r;
    idle_nxt  = idle_r;
    awake_nxt = awake_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    if (cmd.exec) begin
      res_nxt = '0;
      case (op_r)
        vcfm_pkg::OP_BYTE: begin
          case (phase_r)
            PH_HEAD: begin
              if (data_r == vcfm_pkg::HEADER_BYTE) begin
                phase_nxt = PH_CMD;
              end
            end
            PH_CMD: begin
              cmd_nxt   = data_r;
              phase_nxt = PH_CHECK;
            end
            PH_CHECK: begin
              phase_nxt = PH_HEAD;
              if (9'(cmd_r) + 9'(data_r) == 9'(vcfm_pkg::CHECK_SUM)) begin
                pend_nxt = 1'b1;
              end
            end
            default: begin
              phase_nxt = PH_HEAD;
            end
          endcase
        end
        vcfm_pkg::OP_ADD: begin
          if (count_r < CNT_MAX) begin
            count_nxt = count_r + IDX_FIRST;
          end
        end
        vcfm_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        vcfm_pkg::OP_POLL: begin
          if (pend_r) begin
            pend_nxt = 1'b0;
          end
          if (pend_r && (cmd_r == vcfm_pkg::WAKE_COMMAND)) begin
            idle_nxt = '0;
            res_nxt  = WAKE_RES;
          end else if (pend_r && (count_r != '0)) begin
            idx_nxt = IDX_FIRST;
          end else begin
            awake_nxt = slp_awake;
            res_nxt   = slp_res;
          end
        end
        vcfm_pkg::OP_TICK: begin
          if (!asleep) begin
            idle_nxt = idle_r + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.step) begin
      if (hit) begin
        if (!asleep) begin
          idle_nxt                = '0;
          res_nxt.action_valid    = rd_q.has_action;
          res_nxt.action_index    = rd_q.has_action ? 4'(idx_r) : 4'd0;
          res_nxt.sound_valid     = rd_q.sound != '0;
          res_nxt.sound_id        = rd_q.sound;
          res_nxt.sound_repeat    = (rd_q.sound != '0) ? 2'd1 : 2'd0;
        end
      end else if (last) begin
        awake_nxt = slp_awake;
        res_nxt   = slp_res;
      end else begin
        idx_nxt = idx_r + IDX_FIRST;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r + IDX_FIRST] <= '{command: data_r, sound: esnd_r, has_action: eact_r};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= opcode;
      data_r <= data_byte;
      esnd_r <= entry_sound;
      eact_r <= entry_has_action;
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEAD;
      cmd_r       <= '0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      idle_r      <= vcfm_pkg::WAKE_TIMEOUT_RST;
      awake_r     <= 1'b0;
      tmo_r       <= vcfm_pkg::WAKE_TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      idle_r      <= idle_nxt;
      awake_r     <= awake_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tmo_r <= cfg_wdata;
      end
    end
  end

  assign wake_timeout = tmo_r;
  assign out_tvalid   = out_valid_r;
  assign out_res      = out_r;

endmodule

`default_nettype wire

[src/voice_command_frame_matcher_top.sv]
// Voice command frame matcher.
// in_*: one item per transfer. in_tuser carries the opcode (byte, add entry,
//   clear table, poll, tick); in_tdata carries the byte and the entry fields.
// out_*: exactly one result per accepted item, in order, from an output
//   register: action and sound fields, all zero when nothing fires.
// cfg_*: APB write/read of wake_timeout at address 0; write only while idle.
// Timing: one item at a time. A non-poll item, or a poll that needs no table
//   walk, goes from accept through the execute state to the output state.
//   A table walk visits k entries (1 to TABLE_DEPTH-1) in the search state,
//   one entry per cycle through the single registered read port of the table.
//   in_tready rises again as soon as the result is in the output register.
// Stall: while out_tready is low the result holds in the output register and
//   the next item can still be accepted and worked; its result waits until
//   the register is taken.
// Reset: parser waits for a header, table empty, no frame pending, block
//   asleep with wake_timeout 1000; the table contents are not cleared.
`default_nettype none

`include "voice_command_frame_matcher_top_defines.svh"

module voice_command_frame_matcher_top #(
  parameter int unsigned TABLE_DEPTH = vcfm_pkg::TABLE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [7:0] data_byte, [15:8] entry_sound, [16] entry_has_action, [23:17] zero
  input  wire  [23:0] in_tdata,
  // [2:0] opcode
  input  wire  [2:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [0] action_valid, [4:1] action_index, [5] sound_valid, [13:6] sound_id,
  // [15:14] sound_repeat
  output logic [15:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [1:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  vcfm_pkg::ctl_cmd_t cmd;
  vcfm_pkg::dp_sts_t  sts;
  vcfm_pkg::res_t     res;
  logic [15:0]        wake_timeout;
  logic               cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == 2'd0);
  assign cfg_prdata = {16'd0, wake_timeout};

  vcfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vcfm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .opcode           (in_tuser),
    .data_byte        (in_tdata[7:0]),
    .entry_sound      (in_tdata[15:8]),
    .entry_has_action (in_tdata[16]),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_pwdata[15:0]),
    .wake_timeout     (wake_timeout),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_res          (res)
  );

  assign out_tdata = {res.sound_repeat, res.sound_id, res.sound_valid,
                      res.action_index, res.action_valid};

  `VCFM_ASSERT_NEXT(a_one_item_at_a_time, in_tvalid && in_tready, !in_tready)
  `VCFM_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !out_tvalid || out_tready)
  `VCFM_ASSERT_NOW(a_cmd_exclusive, 1'b1,
                   $onehot0({cmd.take, cmd.exec, cmd.step, cmd.out_load}))

endmodule

`default_nettype wire
